// ===== sv/swrl_pkg.sv =====
// Shared constants and codes for the sliding-window rate limiter.
`default_nettype none

package swrl_pkg;

  // Field widths of the channels and registers.
  localparam int MODE_W     = 2;
  localparam int CLIENT_W   = 6;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int MAXREQ_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Default sizes of the log store.
  localparam int CLIENTS_DEF = 64;
  localparam int SLOTS_DEF   = 16;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 1'd1;

  // Register values after reset.
  localparam logic [MAXREQ_W-1:0] MAX_REQ_RST = 5'd10;
  localparam logic [TIME_W-1:0]   WINDOW_RST  = 32'd1000;

endpackage

`default_nettype wire

// ===== sv/swrl_if.sv =====
// Valid/ready channel interfaces for request items and result items.
`default_nettype none

interface swrl_req_if
  import swrl_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CLIENT_W-1:0] client_id;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, output mode, output client_id, output now_ms, input ready);
  modport sink   (input valid, input mode, input client_id, input now_ms, output ready);
endinterface

interface swrl_rsp_if
  import swrl_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               allowed;
  logic [COUNT_W-1:0] current_count;

  modport source (output valid, output allowed, output current_count, input ready);
  modport sink   (input valid, input allowed, input current_count, output ready);
endinterface

`default_nettype wire

// ===== sv/swrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/sliding_window_rate_limiter.sv =====
// Sliding-window log rate limiter: per-client timestamp logs under a small sequencer.
//
// Items arrive on the req channel (mode, client_id, now_ms) and each gives exactly one
// beat on the rsp channel (allowed, current_count). A request drops the expired entries
// at the front of its client's log, then is granted and logged if the log holds fewer
// than max_requests entries (capped at SLOTS). A count query reports the log length
// after the same cleanup. The reset mode empties every log.
// One item is worked on at a time; req.ready is low until it is finished.
// Work on an item: the head/count store is read, then expired entries are popped from
// the front of a nonempty log until an unexpired entry is met or the log is empty, then
// the decision and write-back follow and the result is loaded; the one age subtract and
// compare examines one log entry per cycle. A reset-mode item runs a clearing pass over
// the head/count store, one client at a time. Out-of-range clients and unused modes go
// straight to the result. req.ready returns as the result enters the output register.
// After rst_ni the same clearing pass runs with req.ready low; configuration writes are
// taken at any time. Registers reset to max_requests 10 and window_ms 1000.
// Results sit in an output register: a stalled receiver holds the result, a new item is
// still accepted, and that item waits at its end until the register is free.
`default_nettype none

module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int CLIENTS = CLIENTS_DEF,
  parameter int SLOTS   = SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  swrl_req_if.sink                   req,
  swrl_rsp_if.source                 rsp,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Derived widths.
  localparam int CIW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int HW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW  = $clog2(SLOTS + 1);
  localparam int SUMW  = CNTW + 1;
  localparam int MW    = HW + CNTW;
  localparam int TSD   = CLIENTS * SLOTS;
  localparam int AW    = (TSD > 1) ? $clog2(TSD) : 1;

  localparam logic [AW-1:0]   SLOTS_A     = AW'(SLOTS);
  localparam logic [CNTW-1:0] SLOTS_C     = CNTW'(SLOTS);
  localparam logic [SUMW-1:0] SLOTS_S     = SUMW'(SLOTS);
  localparam logic [HW-1:0]   HEAD_LAST   = HW'(SLOTS - 1);
  localparam logic [CIW-1:0]  CLIENT_LAST = CIW'(CLIENTS - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_META   = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]          state_q;
  logic [CIW-1:0]      clr_q;
  logic                clr_item_q;
  logic [MAXREQ_W-1:0] max_req_q;
  logic [TIME_W-1:0]   window_q;
  logic                out_valid_q;
  logic                out_allowed_q;
  logic [COUNT_W-1:0]  out_count_q;

  // Payload registers of the item at work.
  logic [MODE_W-1:0]   mode_q;
  logic [CIW-1:0]      client_q;
  logic [TIME_W-1:0]   now_q;
  logic [HW-1:0]       head_q;
  logic [CNTW-1:0]     cnt_q;
  logic                res_allowed_q;
  logic [CNTW-1:0]     res_count_q;

  logic                in_fire;
  logic                out_free;
  logic                in_range;
  logic [CIW-1:0]      client_idx;
  logic                meta_we;
  logic [CIW-1:0]      meta_waddr;
  logic [MW-1:0]       meta_wdata;
  logic [MW-1:0]       meta_rdata;
  logic [HW-1:0]       meta_head;
  logic [CNTW-1:0]     meta_cnt;
  logic                ts_we;
  logic [AW-1:0]       ts_waddr;
  logic [AW-1:0]       ts_raddr;
  logic [TIME_W-1:0]   ts_rdata;
  logic [TIME_W-1:0]   age;
  logic                expired;
  logic [HW-1:0]       head_nx;
  logic [CNTW-1:0]     cnt_dec;
  logic [CNTW-1:0]     limit;
  logic                grant;
  logic [CNTW-1:0]     cnt_fin;
  logic [SUMW-1:0]     tail_sum;
  logic [HW-1:0]       tail;

  function automatic logic [AW-1:0] ts_addr(input logic [CIW-1:0] c, input logic [HW-1:0] s);
    return AW'(c) * SLOTS_A + AW'(s);
  endfunction

  // Handshake and item decode.
  assign req.ready  = (state_q == S_IDLE);
  assign in_fire    = req.valid && req.ready;
  assign out_free   = !out_valid_q || rsp.ready;
  assign in_range   = (32'(req.client_id) < 32'(CLIENTS));
  assign client_idx = CIW'(req.client_id);

  assign rsp.valid         = out_valid_q;
  assign rsp.allowed       = out_allowed_q;
  assign rsp.current_count = out_count_q;

  // Head and count of the addressed client as read from the store.
  assign meta_head = meta_rdata[MW-1:CNTW];
  assign meta_cnt  = meta_rdata[CNTW-1:0];

  // Shared age unit: one subtract and compare per cycle.
  assign age     = now_q - ts_rdata;
  assign expired = (age > window_q);
  assign head_nx = (head_q == HEAD_LAST) ? '0 : head_q + HW'(1);
  assign cnt_dec = cnt_q - CNTW'(1);

  // Admission decision and append position.
  assign limit    = (32'(max_req_q) > 32'(SLOTS)) ? SLOTS_C : CNTW'(max_req_q);
  assign grant    = (mode_q == MODE_REQUEST) && (cnt_q < limit);
  assign cnt_fin  = grant ? cnt_q + CNTW'(1) : cnt_q;
  assign tail_sum = SUMW'(head_q) + SUMW'(cnt_q);
  assign tail     = (tail_sum >= SLOTS_S) ? HW'(tail_sum - SLOTS_S) : HW'(tail_sum);

  // Store ports: clearing pass or write-back of the finished client.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = client_q;
    meta_wdata = {head_q, cnt_fin};
    if (state_q == S_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_q;
      meta_wdata = '0;
    end else if (state_q == S_DECIDE) begin
      meta_we = 1'b1;
    end
  end

  assign ts_we    = (state_q == S_DECIDE) && grant;
  assign ts_waddr = ts_addr(client_q, tail);
  assign ts_raddr = (state_q == S_META) ? ts_addr(client_q, meta_head)
                                        : ts_addr(client_q, head_nx);

  swrl_ram #(
    .WIDTH (MW),
    .DEPTH (CLIENTS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (client_idx),
    .rdata_o (meta_rdata)
  );

  swrl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TSD)
  ) u_ts_ram (
    .clk_i   (clk_i),
    .we_i    (ts_we),
    .waddr_i (ts_waddr),
    .wdata_i (now_q),
    .raddr_i (ts_raddr),
    .rdata_o (ts_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q <= MAX_REQ_RST;
      window_q  <= WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_REQ: max_req_q <= cfg_wdata_i[MAXREQ_W-1:0];
        REG_WINDOW:  window_q  <= cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer control state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The output register fills when an item finishes and empties on a result beat.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= (clr_q == CLIENT_LAST) ? '0 : clr_q + CIW'(1);
          if (clr_q == CLIENT_LAST) begin
            state_q <= clr_item_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (req.mode == MODE_RESET) begin
              clr_item_q <= 1'b1;
              state_q    <= S_CLEAR;
            end else if ((req.mode == MODE_REQUEST || req.mode == MODE_QUERY) && in_range) begin
              state_q <= S_META;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_META: begin
          state_q <= (meta_cnt == '0) ? S_DECIDE : S_CMP;
        end
        S_CMP: begin
          if (!expired || cnt_dec == '0) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            clr_item_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload, log cursor and result values.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_q        <= req.mode;
          client_q      <= client_idx;
          now_q         <= req.now_ms;
          res_allowed_q <= 1'b0;
          res_count_q   <= '0;
        end
      end
      S_META: begin
        head_q <= meta_head;
        cnt_q  <= meta_cnt;
      end
      S_CMP: begin
        if (expired) begin
          head_q <= head_nx;
          cnt_q  <= cnt_dec;
        end
      end
      S_DECIDE: begin
        res_allowed_q <= grant;
        res_count_q   <= cnt_fin;
      end
      S_DONE: begin
        if (out_free) begin
          out_allowed_q <= res_allowed_q;
          out_count_q   <= COUNT_W'(res_count_q);
        end
      end
      default: ;
    endcase
  end

  // A reset-mode item always starts the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req.mode == MODE_RESET |=> state_q == S_CLEAR)
    else $error("reset-mode item did not start the clearing pass");

  // The compare loop only runs on a nonempty log.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> cnt_q != '0)
    else $error("expiry compare on an empty log");

  // A granted request always leaves a nonempty log.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.allowed |-> (SLOTS >= 32) || rsp.current_count != '0)
    else $error("grant reported with an empty log");

  // A new result is loaded only when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp.ready |=> out_valid_q && $stable(out_count_q))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
